>>> hdl/evad_pkg.sv
// Shared types and constants for the energy VAD endpoint detector.
`timescale 1ns / 1ps

package evad_pkg;

  // Operation codes carried on s_tuser
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_OPEN   = 2'd2,
    OP_STOP   = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_LOUD_MEAN_SQUARE = 3'd0;
  localparam logic [2:0] CFG_SPEECH_MIN_TIME  = 3'd1;
  localparam logic [2:0] CFG_SILENCE_END_TIME = 3'd2;
  localparam logic [2:0] CFG_MAX_UTTER_TIME   = 3'd3;
  localparam logic [2:0] CFG_TICK_TIME        = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int LMS_W      = 31;
  localparam int TMS_W      = 16;
  localparam int TICK_W     = 10;
  localparam int SAMPLE_W   = 16;
  localparam int SQ_W       = 31;

  // Reset values of the registers
  localparam logic [LMS_W-1:0]  LMS_RESET     = 31'd68719;
  localparam logic [TMS_W-1:0]  SPEECH_RESET  = 16'd400;
  localparam logic [TMS_W-1:0]  SILENCE_RESET = 16'd900;
  localparam logic [TMS_W-1:0]  MAX_RESET     = 16'd20000;
  localparam logic [TICK_W-1:0] TICK_RESET    = 10'd50;

  // Saturating time counters
  localparam int              TIME_W   = 17;
  localparam logic [TIME_W-1:0] TIME_MAX = 17'h1FFFF;

  // Level-measure step from the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } level_step_t;

endpackage

>>> hdl/evad_level.sv
// Block level measure: sum of squares, sample count and loud decision.
`timescale 1ns / 1ps

module evad_level import evad_pkg::*; #(
  parameter int MAX_BLOCK = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             lms_we,
  input  logic [LMS_W-1:0] lms_wdata,
  input  level_step_t      step,
  input  logic [SQ_W-1:0]  sq,
  output logic             loud_next
);

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int ACC_W = SQ_W + CNT_W;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_BLOCK);

  logic [LMS_W-1:0] lms;
  logic [ACC_W-1:0] square_sum;
  logic [ACC_W-1:0] thr;         // lms * block_count, kept incrementally
  logic [CNT_W-1:0] block_count;
  logic             loud_level;

  logic             cnt_ok;
  logic [ACC_W-1:0] sum_add;
  logic [ACC_W-1:0] thr_add;
  logic [CNT_W-1:0] cnt_add;
  logic [ACC_W-1:0] thr_load;

  // Accumulate unless the block is already full
  assign cnt_ok  = block_count < CNT_LIMIT;
  assign sum_add = cnt_ok ? square_sum + ACC_W'(sq) : square_sum;
  assign thr_add = cnt_ok ? thr + ACC_W'(lms) : thr;
  assign cnt_add = cnt_ok ? block_count + CNT_W'(1) : block_count;

  // New threshold product after a write to the mean-square register
  assign thr_load = ACC_W'(lms_wdata) * ACC_W'(block_count);

  // Loud decision at the closing sample; empty block is quiet
  always_comb begin
    loud_next = loud_level;
    if (step.valid && step.last) begin
      loud_next = (cnt_add == '0) ? 1'b0 : (sum_add > thr_add);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lms         <= LMS_RESET;
      square_sum  <= '0;
      thr         <= '0;
      block_count <= '0;
      loud_level  <= 1'b0;
    end else begin
      if (lms_we) begin
        lms <= lms_wdata;
        thr <= thr_load;
      end
      if (step.valid) begin
        loud_level <= loud_next;
        if (step.last) begin
          square_sum  <= '0;
          thr         <= '0;
          block_count <= '0;
        end else begin
          square_sum  <= sum_add;
          thr         <= thr_add;
          block_count <= cnt_add;
        end
      end
    end
  end

endmodule

>>> hdl/energy_vad_endpoint_detector_core.sv
// Top level of the energy VAD endpoint detector.
//
//  channel  dir  handshake         payload
//  s_*      in   tvalid/tready     tdata: sample; tuser: op; tlast: block_last
//  m_*      out  tvalid/tready     tdata: endpoint..speech_heard
//  cfg_*    in   cfg_we            cfg_index, cfg_wdata
//
// One beat per cycle sustained while the output is taken; each beat passes the
// square stage, then the state update into the output register. The 16x16
// square is the only multiplier on the beat path; the threshold product is kept
// by addition. rst is synchronous; it restores register defaults and clears
// the valid flags and the level and turn state. A stalled output holds its
// beat; one more beat may be taken into the square stage while the output waits.
`timescale 1ns / 1ps

module energy_vad_endpoint_detector_core import evad_pkg::*; #(
  parameter int MAX_BLOCK = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [15:0] sample
  input  logic [1:0]            s_tuser,   // [1:0] op
  input  logic                  s_tlast,
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [0] endpoint, [1] endpoint_cause,
                                           // [2] loud, [3] capturing,
                                           // [4] forward, [5] speech_heard
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [TMS_W-1:0]  speech_min_time;
  logic [TMS_W-1:0]  silence_end_time;
  logic [TMS_W-1:0]  max_utter_time;
  logic [TICK_W-1:0] tick_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      speech_min_time  <= SPEECH_RESET;
      silence_end_time <= SILENCE_RESET;
      max_utter_time   <= MAX_RESET;
      tick_time        <= TICK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPEECH_MIN_TIME:  speech_min_time  <= cfg_wdata[TMS_W-1:0];
        CFG_SILENCE_END_TIME: silence_end_time <= cfg_wdata[TMS_W-1:0];
        CFG_MAX_UTTER_TIME:   max_utter_time   <= cfg_wdata[TMS_W-1:0];
        CFG_TICK_TIME:        tick_time        <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: output register advances when empty or taken
  logic valid1;
  logic out_adv;
  logic work;

  assign out_adv  = !m_tvalid || m_tready;
  assign s_tready = !valid1 || out_adv;
  assign work     = valid1 && out_adv;

  // Stage 1: magnitude squared
  logic [SAMPLE_W-1:0] mag;
  logic [SQ_W-1:0]     sq_in;
  op_t                 op1;
  logic                last1;
  logic [SQ_W-1:0]     sq1;

  assign mag   = s_tdata[SAMPLE_W-1] ? (~s_tdata + SAMPLE_W'(1)) : s_tdata;
  assign sq_in = SQ_W'(mag) * SQ_W'(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (s_tready) begin
      valid1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      op1   <= op_t'(s_tuser);
      last1 <= s_tlast;
      sq1   <= sq_in;
    end
  end

  // Level measure
  level_step_t step;
  logic        loud_next;

  assign step.valid = work && (op1 == OP_SAMPLE);
  assign step.last  = last1;

  evad_level #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_level (
    .clk       (clk),
    .rst       (rst),
    .lms_we    (cfg_we && (cfg_index == CFG_LOUD_MEAN_SQUARE)),
    .lms_wdata (cfg_wdata[LMS_W-1:0]),
    .step      (step),
    .sq        (sq1),
    .loud_next (loud_next)
  );

  // Turn and timing state
  logic              turn_open, turn_open_next;
  logic [TIME_W-1:0] speech_time, speech_time_next;
  logic [TIME_W-1:0] quiet_time, quiet_time_next;
  logic              had_speech, had_speech_next;
  logic              end_done, end_done_next;
  logic              endpoint_next, cause_next, forward_next;

  logic [TIME_W:0]   speech_sum, quiet_sum;
  logic [TIME_W-1:0] speech_sat, quiet_sat;
  logic [TIME_W:0]   total;

  assign speech_sum = (TIME_W+1)'(speech_time) + (TIME_W+1)'(tick_time);
  assign quiet_sum  = (TIME_W+1)'(quiet_time) + (TIME_W+1)'(tick_time);
  assign speech_sat = (speech_sum > (TIME_W+1)'(TIME_MAX)) ? TIME_MAX
                                                           : speech_sum[TIME_W-1:0];
  assign quiet_sat  = (quiet_sum > (TIME_W+1)'(TIME_MAX)) ? TIME_MAX
                                                          : quiet_sum[TIME_W-1:0];

  always_comb begin
    turn_open_next   = turn_open;
    speech_time_next = speech_time;
    quiet_time_next  = quiet_time;
    had_speech_next  = had_speech;
    end_done_next    = end_done;
    endpoint_next    = 1'b0;
    cause_next       = 1'b0;
    forward_next     = 1'b0;
    total            = '0;
    case (op1)
      OP_SAMPLE: begin
        forward_next = turn_open;
      end
      OP_TICK: begin
        if (turn_open && !end_done) begin
          if (loud_next) begin
            speech_time_next = speech_sat;
            quiet_time_next  = '0;
            if (speech_sat >= TIME_W'(speech_min_time)) begin
              had_speech_next = 1'b1;
            end
          end else begin
            quiet_time_next = quiet_sat;
            if (had_speech && quiet_sat >= TIME_W'(silence_end_time)) begin
              end_done_next = 1'b1;
              endpoint_next = 1'b1;
            end
          end
          // length limit, only if silence did not already end the turn
          total = (TIME_W+1)'(speech_time_next) + (TIME_W+1)'(quiet_time_next);
          if (!end_done_next && total >= (TIME_W+1)'(max_utter_time)) begin
            end_done_next = 1'b1;
            endpoint_next = 1'b1;
            cause_next    = 1'b1;
          end
        end
      end
      OP_OPEN: begin
        speech_time_next = '0;
        quiet_time_next  = '0;
        had_speech_next  = 1'b0;
        end_done_next    = 1'b0;
        turn_open_next   = 1'b1;
      end
      OP_STOP: begin
        turn_open_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_open   <= 1'b0;
      speech_time <= '0;
      quiet_time  <= '0;
      had_speech  <= 1'b0;
      end_done    <= 1'b0;
    end else if (work) begin
      turn_open   <= turn_open_next;
      speech_time <= speech_time_next;
      quiet_time  <= quiet_time_next;
      had_speech  <= had_speech_next;
      end_done    <= end_done_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      m_tdata <= {2'b00, had_speech_next, forward_next, turn_open_next,
                  loud_next, cause_next, endpoint_next};
    end
  end

endmodule

>>> sim/energy_vad_endpoint_detector_core_tb.sv
// Self-checking testbench for the energy VAD endpoint detector core.
`timescale 1ns / 1ps

module energy_vad_endpoint_detector_core_tb;
  import evad_pkg::*;

  localparam int BLOCK_LIMIT = 4096;

  // Result flags, endpoint in bit 0 as on m_tdata
  typedef struct packed {
    logic speech_heard;
    logic forward;
    logic capturing;
    logic loud;
    logic cause;
    logic endpoint;
  } vad_flags_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;   // [15:0] sample
  logic [1:0]            s_tuser = OP_SAMPLE;   // [1:0] op
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;   // [0] endpoint, [1] cause, [2] loud, [3] capturing,
                                    // [4] forward, [5] speech_heard
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  energy_vad_endpoint_detector_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor copy of the registers
  logic [LMS_W-1:0]  thr;
  logic [TMS_W-1:0]  min_speech;
  logic [TMS_W-1:0]  sil_end;
  logic [TMS_W-1:0]  max_utter;
  logic [TICK_W-1:0] tick_ms;

  // Predictor copy of the detector state
  logic [42:0]       acc_sum;
  logic [12:0]       blk_cnt;
  logic              loud_lvl;
  logic              turn_open;
  logic [TIME_W-1:0] speech_ms;
  logic [TIME_W-1:0] quiet_ms;
  logic              heard;
  logic              ended;

  vad_flags_t flags_q[$];
  int         mismatches = 0;
  int         beats_sent = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  function automatic logic [TIME_W-1:0] sat_ms(logic [TIME_W-1:0] base,
                                                 logic [TICK_W-1:0] step);
    logic [TIME_W:0] s;
    s = base + step;
    return (s > TIME_MAX) ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  // Advance the predicted state by one input beat and return its flags
  function automatic vad_flags_t step_detector(op_t op, logic [15:0] smp, logic last);
    vad_flags_t      f;
    logic [16:0]     mag;
    logic [TIME_W:0] total;
    f = '0;
    case (op)
      OP_SAMPLE: begin
        mag = smp[15] ? 17'(17'h10000 - {1'b0, smp}) : {1'b0, smp};
        f.forward = turn_open;
        // samples past the block limit are dropped until the marker
        if (blk_cnt < 13'(BLOCK_LIMIT)) begin
          acc_sum += 43'(mag) * 43'(mag);
          blk_cnt++;
        end
        if (last) begin
          loud_lvl = (blk_cnt == 0) ? 1'b0 : (64'(acc_sum) > 64'(thr) * 64'(blk_cnt));
          acc_sum = '0;
          blk_cnt = '0;
        end
      end
      OP_TICK: begin
        if (turn_open && !ended) begin
          if (loud_lvl) begin
            speech_ms = sat_ms(speech_ms, tick_ms);
            quiet_ms = '0;
            if (speech_ms >= min_speech) heard = 1'b1;
          end else begin
            quiet_ms = sat_ms(quiet_ms, tick_ms);
            if (heard && quiet_ms >= sil_end) begin
              ended = 1'b1;
              f.endpoint = 1'b1;
            end
          end
          // silence end wins over the length limit on the same tick
          total = {1'b0, speech_ms} + {1'b0, quiet_ms};
          if (!ended && total >= max_utter) begin
            ended = 1'b1;
            f.endpoint = 1'b1;
            f.cause = 1'b1;
          end
        end
      end
      OP_OPEN: begin
        speech_ms = '0;
        quiet_ms = '0;
        heard = 1'b0;
        ended = 1'b0;
        turn_open = 1'b1;
      end
      default: turn_open = 1'b0;
    endcase
    f.loud = loud_lvl;
    f.capturing = turn_open;
    f.speech_heard = heard;
    return f;
  endfunction

  // Send one beat, idling at random first; predict once it is taken
  task automatic send_beat(op_t op, logic [15:0] smp, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= smp;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    flags_q = {flags_q, step_detector(op, smp, last)};
    beats_sent++;
  endtask

  // Hold off the sender until every expected result is out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (flags_q.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg_we high; load_config lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_LOUD_MEAN_SQUARE: thr = val[LMS_W-1:0];
      CFG_SPEECH_MIN_TIME:  min_speech = val[TMS_W-1:0];
      CFG_SILENCE_END_TIME: sil_end = val[TMS_W-1:0];
      CFG_MAX_UTTER_TIME:   max_utter = val[TMS_W-1:0];
      CFG_TICK_TIME:        tick_ms = val[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [LMS_W-1:0] lms, logic [TMS_W-1:0] smin,
                             logic [TMS_W-1:0] sil, logic [TMS_W-1:0] maxu,
                             logic [TICK_W-1:0] tick);
    drain();
    write_reg(CFG_LOUD_MEAN_SQUARE, CFG_DATA_W'(lms));
    write_reg(CFG_SPEECH_MIN_TIME, CFG_DATA_W'(smin));
    write_reg(CFG_SILENCE_END_TIME, CFG_DATA_W'(sil));
    write_reg(CFG_MAX_UTTER_TIME, CFG_DATA_W'(maxu));
    write_reg(CFG_TICK_TIME, CFG_DATA_W'(tick));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [TMS_W-1:0] clip_ms(int unsigned ms);
    return (ms > 65535) ? 16'hFFFF : TMS_W'(ms);
  endfunction

  // Times scaled to a few ticks so that both endpoint causes come up
  task automatic random_config();
    int unsigned tick;
    tick = $urandom_range(1, 1023);
    load_config(LMS_W'($urandom_range(0, 32'h0FFF_FFFF)),
                clip_ms(tick * $urandom_range(0, 6)),
                clip_ms(tick * $urandom_range(0, 8)),
                clip_ms(tick * $urandom_range(4, 40)), TICK_W'(tick));
  endtask

  function automatic logic [15:0] rand_sample(logic loud_blk);
    return loud_blk ? 16'($urandom) : 16'($urandom_range(0, 128)) - 16'd64;
  endfunction

  // Turns: open, blocks of samples each closed by a tick, mostly a stop; some noise.
  // A turn is cut short once n beats have gone out.
  task automatic run_turns(int n);
    int   stop_at;
    int   blk_len;
    int   ticks;
    logic loud_blk;
    stop_at = beats_sent + n;
    loud_blk = 1'($urandom);
    while (beats_sent < stop_at) begin
      if ($urandom_range(99) < 8) begin
        send_beat(op_t'($urandom_range(3)), 16'($urandom), 1'($urandom));
      end else begin
        send_beat(OP_OPEN, 16'($urandom), 1'($urandom));
        ticks = $urandom_range(1, 70);
        for (int t = 0; t < ticks && beats_sent < stop_at; t++) begin
          if ($urandom_range(9) != 0) begin
            // level runs, so speech time can build up
            if ($urandom_range(9) < 3) loud_blk = !loud_blk;
            blk_len = $urandom_range(1, 4);
            for (int k = 0; k < blk_len; k++)
              send_beat(OP_SAMPLE, rand_sample(loud_blk), k == blk_len - 1);
          end
          send_beat(OP_TICK, 16'($urandom), 1'($urandom));
        end
        if ($urandom_range(9) != 0) send_beat(OP_STOP, 16'($urandom), 1'($urandom));
      end
    end
  endtask

  // Level decision at the default threshold, markers on other ops, forwarding
  task automatic test_block_level();
    send_beat(OP_TICK, 16'h0000, 1'b1);
    send_beat(OP_STOP, 16'hFFFF, 1'b0);
    send_beat(OP_SAMPLE, 16'h7FFF, 1'b1);
    send_beat(OP_SAMPLE, 16'h8000, 1'b0);
    send_beat(OP_SAMPLE, 16'h0000, 1'b1);
    send_beat(OP_SAMPLE, 16'd262, 1'b1);
    send_beat(OP_SAMPLE, 16'd263, 1'b1);
    send_beat(OP_SAMPLE, 16'hFEFA, 1'b1);
    send_beat(OP_SAMPLE, 16'hFEF9, 1'b1);
    send_beat(OP_SAMPLE, 16'h0000, 1'b1);
    send_beat(OP_OPEN, 16'h5555, 1'b1);
    send_beat(OP_SAMPLE, 16'hAAAA, 1'b1);
    send_beat(OP_STOP, 16'h0000, 1'b1);
  endtask

  // Silence after speech, a tick after the endpoint, then the length limit
  task automatic test_endpoint_causes();
    load_config(LMS_RESET, 16'd100, 16'd150, 16'd400, 10'd50);
    send_beat(OP_OPEN, 16'h0000, 1'b0);
    send_beat(OP_SAMPLE, 16'h7FFF, 1'b1);
    repeat (2) send_beat(OP_TICK, 16'h0000, 1'b0);
    send_beat(OP_SAMPLE, 16'h0000, 1'b1);
    repeat (4) send_beat(OP_TICK, 16'h0000, 1'b0);
    send_beat(OP_STOP, 16'h0000, 1'b0);
    send_beat(OP_TICK, 16'h0000, 1'b0);
    send_beat(OP_OPEN, 16'h0000, 1'b0);
    repeat (8) send_beat(OP_TICK, 16'h0000, 1'b0);
    send_beat(OP_STOP, 16'h0000, 1'b0);
  endtask

  task automatic test_default_turns();
    load_config(LMS_RESET, SPEECH_RESET, SILENCE_RESET, MAX_RESET, TICK_RESET);
    run_turns(300);
  endtask

  // All-zero registers end each turn at its first tick; all-ones never go loud
  task automatic test_register_extremes();
    load_config('0, '0, '0, '0, '0);
    run_turns(150);
    load_config('1, '1, '1, '1, '1);
    run_turns(250);
  endtask

  task automatic test_random_settings();
    random_config();
    run_turns(300);
    load_config(LMS_W'($urandom), TMS_W'($urandom), TMS_W'($urandom),
                TMS_W'($urandom), TICK_W'($urandom));
    run_turns(300);
    random_config();
    run_turns(300);
  endtask

  task automatic check_field(string name, logic want, logic got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %b actual %b", $time, name, want, got);
    end
  endtask

  // Result side: random stalls, compare each beat with the oldest prediction
  always @(posedge clk) begin : result_check
    vad_flags_t want;
    vad_flags_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = vad_flags_t'(m_tdata[5:0]);
        if (flags_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat expected none actual %b", $time, got);
        end else begin
          want = flags_q.pop_front();
          check_field("endpoint", want.endpoint, got.endpoint);
          check_field("endpoint_cause", want.cause, got.cause);
          check_field("loud", want.loud, got.loud);
          check_field("capturing", want.capturing, got.capturing);
          check_field("forward", want.forward, got.forward);
          check_field("speech_heard", want.speech_heard, got.speech_heard);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    // predictor starts from the reset state
    thr = LMS_RESET;
    min_speech = SPEECH_RESET;
    sil_end = SILENCE_RESET;
    max_utter = MAX_RESET;
    tick_ms = TICK_RESET;
    acc_sum = '0;
    blk_cnt = '0;
    loud_lvl = 1'b0;
    turn_open = 1'b0;
    speech_ms = '0;
    quiet_ms = '0;
    heard = 1'b0;
    ended = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 35;
    recv_idle_pct = 67;
    test_block_level();
    test_endpoint_causes();
    test_default_turns();

    send_idle_pct = 67;
    recv_idle_pct = 35;
    test_register_extremes();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_settings();

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
